>>> hdl/psc_pkg.sv
// psc_pkg: shared types, register indexes and fixed-point limits for the pid speed controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package psc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_CLOCKWISE = 3'd4;

    localparam logic [19:0] STOP_THRESHOLD = 20'd26;
    localparam int ONE_Q16  = 65536;
    localparam int TERM_MAX = 1048575;
    localparam int TERM_MIN = -1048576;

    typedef struct packed {
        logic [23:0] prop_gain;
        logic [23:0] integ_gain;
        logic [23:0] deriv_gain;
        logic [19:0] target_speed;
        logic        spin_clockwise;
    } cfg_t;

    typedef struct packed {
        logic signed [20:0] last_error;
        logic signed [17:0] integral;
    } state_t;

    typedef struct packed {
        logic [16:0]        throttle;
        logic               clockwise;
        logic               stopped;
        logic signed [20:0] proportional;
        logic signed [17:0] integral;
        logic signed [20:0] derivative;
    } result_t;

    // saturate a shifted product to the 21 bit term range
    function automatic logic signed [20:0] sat_term(input logic signed [39:0] v);
        logic signed [20:0] r;
        if (v > TERM_MAX)
        begin
            r = 21'(TERM_MAX);
        end
        else if (v < TERM_MIN)
        begin
            r = 21'(TERM_MIN);
        end
        else
        begin
            r = v[20:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/pid_speed_controller.sv
// pid_speed_controller: top level, input register, controller state and result register
// depends on psc_pkg, psc_cfg_regs and psc_terms
// an accepted item passes through the input register, then the result register, to result valid
// throughput: 1 item per cycle unless stalled; combinational multiply, clamp, state update
// reset: asynchronous active low, clears config registers, error and integral state, valid flags
`timescale 1ns / 1ps

module pid_speed_controller
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // measured_speed[19:0], zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // throttle[16:0], clockwise[17], proportional_term[38:18], integral_term[56:39],
    // derivative_term[77:57], zero pad
    output logic [79:0]          m_axis_tdata,
    output logic                 m_axis_tuser   // stopped
);

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t out_result_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic [19:0] s1_speed_reg;
    logic    advance;
    logic    in_accept;

    psc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psc_terms u_terms (
        .measured_speed (s1_speed_reg),
        .cfg            (cfg),
        .state          (state_reg),
        .result         (result_next),
        .state_next     (state_next)
    );

    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_speed_reg <= s_axis_tdata[19:0];
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.stopped;
    assign m_axis_tdata  = {2'b00,
                            out_result_reg.derivative,
                            out_result_reg.integral,
                            out_result_reg.proportional,
                            out_result_reg.clockwise,
                            out_result_reg.throttle};

`ifndef NO_ASSERTIONS
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (out_result_reg.throttle == '0 && out_result_reg.integral == '0))
        else $error("stopped item carries nonzero throttle or integral");

    a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_result_reg.throttle <= 17'(ONE_Q16)))
        else $error("throttle above full scale");

    a_integral_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.integral <= ONE_Q16) && (state_reg.integral >= -ONE_Q16))
        else $error("integral state out of clamp range");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are full and stalled");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced item not presented on output");
`endif

endmodule

>>> hdl/psc_cfg_regs.sv
// psc_cfg_regs: configuration register file for gains, setpoint and direction
// depends on psc_pkg
`timescale 1ns / 1ps

module psc_cfg_regs
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROP_GAIN:      cfg_next.prop_gain      = cfg_data;
                REG_INTEG_GAIN:     cfg_next.integ_gain     = cfg_data;
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = cfg_data;
                REG_TARGET_SPEED:   cfg_next.target_speed   = cfg_data[19:0];
                REG_SPIN_CLOCKWISE: cfg_next.spin_clockwise = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/psc_terms.sv
// psc_terms: combinational p, i and d terms, throttle clamp and next controller state
// depends on psc_pkg
`timescale 1ns / 1ps

module psc_terms
    import psc_pkg::*;
(
    input  logic [19:0] measured_speed,
    input  cfg_t        cfg,
    input  state_t      state,
    output result_t     result,
    output state_t      state_next
);

    logic signed [20:0] err;
    logic signed [21:0] err_delta;
    logic signed [24:0] kp_s;
    logic signed [24:0] ki_s;
    logic signed [24:0] kd_s;
    logic signed [45:0] prod_p;
    logic signed [45:0] prod_i;
    logic signed [46:0] prod_d;
    logic signed [20:0] p_sat;
    logic signed [20:0] d_sat;
    logic signed [38:0] integ_sum;
    logic signed [17:0] integ_clamped;
    logic signed [22:0] total;
    logic [16:0]        throttle;
    logic               stop;

    assign err       = $signed({1'b0, cfg.target_speed}) - $signed({1'b0, measured_speed});
    assign err_delta = {err[20], err} - {state.last_error[20], state.last_error};

    assign kp_s = $signed({1'b0, cfg.prop_gain});
    assign ki_s = $signed({1'b0, cfg.integ_gain});
    assign kd_s = $signed({1'b0, cfg.deriv_gain});

    assign prod_p = kp_s * err;
    assign prod_i = ki_s * err;
    assign prod_d = kd_s * err_delta;

    // dropping the low 8 bits is a floor shift
    assign p_sat = sat_term({{2{prod_p[45]}}, prod_p[45:8]});
    assign d_sat = sat_term({prod_d[46], prod_d[46:8]});

    assign integ_sum = {{21{state.integral[17]}}, state.integral}
                     + {prod_i[45], prod_i[45:8]};

    always_comb
    begin
        if (integ_sum > ONE_Q16)
        begin
            integ_clamped = 18'(ONE_Q16);
        end
        else if (integ_sum < -ONE_Q16)
        begin
            integ_clamped = 18'(-ONE_Q16);
        end
        else
        begin
            integ_clamped = integ_sum[17:0];
        end
    end

    assign total = {{2{p_sat[20]}}, p_sat}
                 + {{5{integ_clamped[17]}}, integ_clamped}
                 + {{2{d_sat[20]}}, d_sat};

    always_comb
    begin
        if (total[22])
        begin
            throttle = '0;
        end
        else if (total > ONE_Q16)
        begin
            throttle = 17'(ONE_Q16);
        end
        else
        begin
            throttle = total[16:0];
        end
    end

    assign stop = (cfg.target_speed < STOP_THRESHOLD);

    always_comb
    begin
        result.clockwise = cfg.spin_clockwise;
        if (stop)
        begin
            result.throttle     = '0;
            result.stopped      = 1'b1;
            result.proportional = '0;
            result.integral     = '0;
            result.derivative   = '0;
            state_next          = '0;
        end
        else
        begin
            result.throttle     = throttle;
            result.stopped      = 1'b0;
            result.proportional = p_sat;
            result.integral     = integ_clamped;
            result.derivative   = d_sat;
            state_next.last_error = err;
            state_next.integral   = integ_clamped;
        end
    end

endmodule

>>> dv/psc_checker.sv
// psc_checker: watches the config, speed and result channels of pid_speed_controller,
// predicts every controller output and compares it field by field
// depends on psc_pkg
`timescale 1ns / 1ps

module psc_checker
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // measured_speed[19:0], zero pad
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // throttle[16:0], clockwise[17], proportional_term[38:18], integral_term[56:39],
    // derivative_term[77:57], zero pad
    input  logic [79:0]          m_axis_tdata,
    input  logic                 m_axis_tuser,  // stopped
    output int                   error_count,
    output int                   pending_count,
    output int                   tick_count,
    output int                   stopped_count,
    output int                   full_count
);

    cfg_t    regs;
    longint  prev_error;
    longint  integ_acc;
    result_t predicted_outputs[$];
    result_t want;

    function automatic longint bound(input longint v, input longint lo, input longint hi);
        longint r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // one control tick: updates the error and integral memory
    function automatic result_t pid_tick(input logic [19:0] speed);
        result_t res;
        longint  err;
        longint  p;
        longint  d;
        longint  total;
        res = '0;
        res.clockwise = regs.spin_clockwise;
        if (regs.target_speed < STOP_THRESHOLD)
        begin
            prev_error  = 0;
            integ_acc   = 0;
            res.stopped = 1'b1;
        end
        else
        begin
            err = longint'(regs.target_speed) - longint'(speed);
            p = bound((longint'(regs.prop_gain) * err) >>> 8, TERM_MIN, TERM_MAX);
            integ_acc = bound(integ_acc + ((longint'(regs.integ_gain) * err) >>> 8),
                              -ONE_Q16, ONE_Q16);
            d = bound((longint'(regs.deriv_gain) * (err - prev_error)) >>> 8,
                      TERM_MIN, TERM_MAX);
            prev_error = err;
            total = bound(p + integ_acc + d, 0, ONE_Q16);
            res.throttle     = 17'(total);
            res.proportional = 21'(p);
            res.integral     = 18'(integ_acc);
            res.derivative   = 21'(d);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        error_count = error_count + 1;
    endtask

    task automatic compare_field(input string name, input longint got, input longint exp_v);
        if (got != exp_v)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d (tick %0d)",
                                      name, got, exp_v, tick_count));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs       = '0;
            prev_error = 0;
            integ_acc  = 0;
            predicted_outputs.delete();
            error_count   = 0;
            pending_count = 0;
            tick_count    = 0;
            stopped_count = 0;
            full_count    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:      regs.prop_gain      = cfg_data;
                    REG_INTEG_GAIN:     regs.integ_gain     = cfg_data;
                    REG_DERIV_GAIN:     regs.deriv_gain     = cfg_data;
                    REG_TARGET_SPEED:   regs.target_speed   = cfg_data[19:0];
                    REG_SPIN_CLOCKWISE: regs.spin_clockwise = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (m_axis_tuser)
                begin
                    stopped_count = stopped_count + 1;
                end
                if (m_axis_tdata[16:0] == 17'(ONE_Q16))
                begin
                    full_count = full_count + 1;
                end
                if (predicted_outputs.size() == 0)
                begin
                    report_mismatch("result item with nothing expected");
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    compare_field("throttle", longint'(m_axis_tdata[16:0]),
                                  longint'(want.throttle));
                    compare_field("clockwise", longint'(m_axis_tdata[17]),
                                  longint'(want.clockwise));
                    compare_field("stopped", longint'(m_axis_tuser), longint'(want.stopped));
                    compare_field("proportional", longint'($signed(m_axis_tdata[38:18])),
                                  longint'(want.proportional));
                    compare_field("integral", longint'($signed(m_axis_tdata[56:39])),
                                  longint'(want.integral));
                    compare_field("derivative", longint'($signed(m_axis_tdata[77:57])),
                                  longint'(want.derivative));
                end
                tick_count = tick_count + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_outputs.push_back(pid_tick(s_axis_tdata[19:0]));
            end
            pending_count = predicted_outputs.size();
        end
    end

endmodule

>>> dv/testbench.sv
// testbench: drives register settings and speed items into pid_speed_controller with
// random gaps and back-pressure; depends on psc_pkg, pid_speed_controller and psc_checker
`timescale 1ns / 1ps

module testbench;
    import psc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [23:0]          cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata;   // measured_speed[19:0], zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [79:0]          m_axis_tdata;   // throttle, clockwise, p, i, d terms
    logic                 m_axis_tuser;   // stopped

    int  error_count;
    int  pending_count;
    int  tick_count;
    int  stopped_count;
    int  full_count;
    int  settings_count;
    int  items_sent;
    bit  sender_gaps;
    bit  receiver_stalls;
    bit  hold_request;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pid_speed_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    psc_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .pending_count (pending_count),
        .tick_count    (tick_count),
        .stopped_count (stopped_count),
        .full_count    (full_count)
    );

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (80) @(negedge clk);
            end
            else if (receiver_stalls && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_regs(input cfg_t c, input bit add_bogus);
        put_reg(REG_PROP_GAIN, c.prop_gain);
        put_reg(REG_INTEG_GAIN, c.integ_gain);
        put_reg(REG_DERIV_GAIN, c.deriv_gain);
        put_reg(REG_TARGET_SPEED, {4'b0, c.target_speed});
        put_reg(REG_SPIN_CLOCKWISE, {23'b0, c.spin_clockwise});
        if (add_bogus)
        begin
            put_reg(REG_SPIN_CLOCKWISE + 3'($urandom_range(1, 3)), 24'($urandom));
        end
        cfg_valid <= 1'b0;
        settings_count = settings_count + 1;
    endtask

    task automatic send_speed(input logic [19:0] speed);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, speed};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent = items_sent + 1;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [23:0] pick_gain();
        logic [23:0] g;
        case ($urandom_range(0, 5))
            0:       g = 24'h0;
            1:       g = 24'hFFFFFF;
            2:       g = 24'($urandom);
            5:       g = 24'($urandom_range(0, 'hFFF));
            default: g = 24'($urandom_range(0, 'h3FFFF));
        endcase
        return g;
    endfunction

    function automatic logic [19:0] pick_target();
        logic [19:0] t;
        case ($urandom_range(0, 9))
            0:       t = 20'($urandom_range(0, 25));
            1:       t = STOP_THRESHOLD;
            2:       t = 20'hFFFFF;
            default: t = 20'($urandom_range(26, 'hFFFFF));
        endcase
        return t;
    endfunction

    // mostly near the setpoint so the error stays small
    function automatic logic [19:0] pick_speed(input logic [19:0] target);
        int          v;
        logic [19:0] s;
        case ($urandom_range(0, 9))
            7:       s = 20'($urandom);
            8:       s = 20'h0;
            9:       s = 20'hFFFFF;
            default:
            begin
                v = int'(target) + int'($urandom_range(0, 4095)) - 2048;
                if (v < 0)
                begin
                    v = 0;
                end
                else if (v > 'hFFFFF)
                begin
                    v = 'hFFFFF;
                end
                s = 20'(v);
            end
        endcase
        return s;
    endfunction

    initial
    begin
        cfg_t c;
        int   n;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        settings_count  = 0;
        items_sent      = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_request    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: setpoint zero, so every tick is a forced stop
        send_speed(20'h0);
        send_speed(20'hFFFFF);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // all at maximum: positive saturation, then error step back to zero
        write_regs('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 1'b1}, 1'b0);
        send_speed(20'h0);
        send_speed(20'hFFFFF);
        send_speed(20'h0);
        send_speed(20'hFFFFF);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // lowest running setpoint: negative integral clamp, zero throttle
        write_regs('{24'h010000, 24'hFFFFFF, 24'h000100, STOP_THRESHOLD, 1'b0}, 1'b1);
        send_speed(20'hFFFFF);
        send_speed(STOP_THRESHOLD);
        send_speed(20'h0);
        send_speed(20'd1000);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // just under the threshold clears the memory
        write_regs('{24'h010000, 24'hFFFFFF, 24'h000100, STOP_THRESHOLD - 20'd1, 1'b1},
                   1'b0);
        send_speed(20'd300);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        write_regs('{24'h008000, 24'h000400, 24'h020000, STOP_THRESHOLD, 1'b0}, 1'b0);
        send_speed(STOP_THRESHOLD);
        send_speed(20'h0);
        send_speed(20'd12345);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        for (int ph = 0; ph < 32; ph++)
        begin
            sender_gaps     = (ph < 29);
            receiver_stalls = (ph < 29);
            c.prop_gain      = pick_gain();
            c.integ_gain     = pick_gain();
            c.deriv_gain     = pick_gain();
            c.target_speed   = pick_target();
            c.spin_clockwise = 1'($urandom);
            if (ph == 0)
            begin
                c = '{24'h0, 24'h0, 24'h0, 20'hFFFFF, 1'b0};
            end
            write_regs(c, $urandom_range(0, 3) == 0);
            n = $urandom_range(30, 70);
            if (ph == 6)
            begin
                // long result hold-off while items keep coming
                sender_gaps  = 1'b0;
                hold_request = 1'b1;
                n = 60;
            end
            repeat (n)
            begin
                send_speed(pick_speed(c.target_speed));
            end
            s_axis_tvalid <= 1'b0;
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("run covered %0d speed items and %0d results over %0d register settings",
                 items_sent, tick_count, settings_count);
        $display("%0d ticks were forced stops, %0d ran at full throttle",
                 stopped_count, full_count);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
